FILE: design/fsia_pkg.sv
// shared constants, types and the digit-to-character function
// for the integer-to-ascii format stream; no dependencies
package fsia_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int ARG_WIDTH   = 32;
   localparam int CHAR_WIDTH  = 8;
   localparam int COUNT_WIDTH = 31;

   // decimal digits of the widest magnitude; always at least the hex digit count
   localparam int NUM_DIGITS  = ((VALUE_WIDTH * 1233) / 4096) + 1;
   localparam int BCD_WIDTH   = NUM_DIGITS * 4;
   localparam int REM_WIDTH   = $clog2(NUM_DIGITS + 1);
   localparam int BIT_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [CHAR_WIDTH-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [CHAR_WIDTH-1:0] CHAR_DEC     = 8'h64;
   localparam logic [CHAR_WIDTH-1:0] CHAR_HEX     = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2d;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;

   typedef struct packed {
      logic load;
      logic is_hex;
      logic take;
   } conv_ctl_type;

   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic [CHAR_WIDTH-1:0] chr;
   } conv_out_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [3:0] digit);
      logic [CHAR_WIDTH-1:0] code;
      if (digit < 4'd10) begin
         code = CHAR_ZERO + CHAR_WIDTH'(digit);
      end else begin
         code = CHAR_LOWER_A + CHAR_WIDTH'(digit - 4'd10);
      end
      return code;
   endfunction

endpackage

FILE: design/format_stream_int_to_ascii.sv
// channel   dir  ports                                             transfer when
// req       in   req_format_char req_argument req_start_of_format  req_valid & !req_stall
// rsp       out  rsp_out_char rsp_last_of_run rsp_char_count       rsp_valid & !rsp_stall
//
// one format byte at a time; a plain byte passes through ST_ECHO, a '%' only sets the pending flag
// %d: after the transfer, each value bit (32) is shifted into the double-dabble shift
// register, then each decimal digit position (10) is stepped through, leading zeros included
// %x: after the transfer, the 10 digit positions are stepped through, leading zeros included
// reset (synchronous, active high) clears the state, pending flag, count and output valid
// the output register holds a result under rsp_stall; the digit unit waits on it
// top level of the formatter; uses fsia_pkg and fsia_digits
module format_stream_int_to_ascii (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fsia_pkg::CHAR_WIDTH-1:0]   req_format_char,
   input  logic [fsia_pkg::ARG_WIDTH-1:0]    req_argument,
   input  logic                              req_start_of_format,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fsia_pkg::CHAR_WIDTH-1:0]   rsp_out_char,
   output logic                              rsp_last_of_run,
   output logic [fsia_pkg::COUNT_WIDTH-1:0]  rsp_char_count
);
   import fsia_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ECHO   = 2'd1;
   localparam logic [1:0] ST_MINUS  = 2'd2;
   localparam logic [1:0] ST_DIGITS = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic                   pend_ff, pend_in;
   logic [CHAR_WIDTH-1:0]  char_ff, char_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   logic                   accept;
   logic                   pending;
   logic                   slot_free;
   logic                   push;
   logic                   push_last;
   logic [CHAR_WIDTH-1:0]  push_char;
   logic [COUNT_WIDTH-1:0] count_base;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic [63:0]            arg_ext;
   logic [VALUE_WIDTH-1:0] val;
   logic [VALUE_WIDTH-1:0] neg_val;
   logic                   is_neg;
   conv_ctl_type           conv_ctl;
   conv_out_type           conv_out;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign pending   = pend_ff && !req_start_of_format;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign arg_ext = 64'(req_argument);
   assign val     = arg_ext[VALUE_WIDTH-1:0];
   assign neg_val = ~val + VALUE_WIDTH'(1);
   assign is_neg  = val[VALUE_WIDTH-1];

   assign conv_ctl.load   = accept && pending
                            && (req_format_char == CHAR_DEC || req_format_char == CHAR_HEX);
   assign conv_ctl.is_hex = (req_format_char == CHAR_HEX);
   assign conv_ctl.take   = (state_ff == ST_DIGITS) && slot_free;

   fsia_digits u_digits (
      .clock     (clock),
      .reset     (reset),
      .ctl       (conv_ctl),
      .magnitude ((conv_ctl.is_hex || !is_neg) ? val : neg_val),
      .dout      (conv_out)
   );

   always_comb begin
      push      = 1'b0;
      push_last = 1'b0;
      push_char = char_ff;
      case (state_ff)
         ST_ECHO: begin
            push      = slot_free;
            push_last = 1'b1;
            push_char = char_ff;
         end
         ST_MINUS: begin
            push      = slot_free;
            push_last = 1'b0;
            push_char = CHAR_MINUS;
         end
         ST_DIGITS: begin
            push      = slot_free && conv_out.valid;
            push_last = conv_out.last;
            push_char = conv_out.chr;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   assign count_base = count_ff;
   assign count_inc  = (count_base == COUNT_MAX) ? count_base
                                                 : count_base + COUNT_WIDTH'(1);

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      char_in  = char_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_start_of_format) begin
                  count_in = '0;
                  pend_in  = 1'b0;
               end
               if (pending) begin
                  pend_in = 1'b0;
                  if (req_format_char == CHAR_DEC) begin
                     state_in = is_neg ? ST_MINUS : ST_DIGITS;
                  end else if (req_format_char == CHAR_HEX) begin
                     state_in = ST_DIGITS;
                  end
               end else if (req_format_char == CHAR_PERCENT) begin
                  pend_in = 1'b1;
               end else begin
                  char_in  = req_format_char;
                  state_in = ST_ECHO;
               end
            end
         end
         ST_ECHO: begin
            if (push) begin
               state_in = ST_IDLE;
            end
         end
         ST_MINUS: begin
            if (push) begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (push && push_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (push) begin
         count_in = count_inc;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = push_char;
         rsp_last_in  = push_last;
         rsp_count_in = count_inc;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff      <= char_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_char_count  = rsp_count_ff;

endmodule

FILE: design/fsia_digits.sv
// digit unit: bit-serial double-dabble for decimal, direct nibble load for hex,
// then one digit per cycle from the top while ctl.take allows, with leading zeros dropped; uses fsia_pkg
module fsia_digits (
   input  logic                              clock,
   input  logic                              reset,
   input  fsia_pkg::conv_ctl_type            ctl,
   input  logic [fsia_pkg::VALUE_WIDTH-1:0]  magnitude,
   output fsia_pkg::conv_out_type            dout
);
   import fsia_pkg::*;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_DABBLE = 2'd1;
   localparam logic [1:0] PH_EMIT   = 2'd2;

   logic [1:0]               phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0]   bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]     bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0]     adj;
   logic [BIT_CNT_WIDTH-1:0] bitcnt_ff, bitcnt_in;
   logic [REM_WIDTH-1:0]     rem_ff, rem_in;
   logic                     started_ff, started_in;
   logic [3:0]               top;
   logic                     shows;

   always_comb begin
      logic [3:0] nib;
      nib = 4'd0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         nib = bcd_ff[i*4 +: 4];
         adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
   end

   assign top   = bcd_ff[BCD_WIDTH-1 -: 4];
   assign shows = started_ff || (top != 4'd0) || (rem_ff == REM_WIDTH'(1));

   assign dout.valid = (phase_ff == PH_EMIT) && shows;
   assign dout.last  = (rem_ff == REM_WIDTH'(1));
   assign dout.chr   = digit_char(top);

   always_comb begin
      phase_in   = phase_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bitcnt_in  = bitcnt_ff;
      rem_in     = rem_ff;
      started_in = started_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (ctl.load) begin
               started_in = 1'b0;
               rem_in     = REM_WIDTH'(NUM_DIGITS);
               if (ctl.is_hex) begin
                  bcd_in   = BCD_WIDTH'(magnitude);
                  phase_in = PH_EMIT;
               end else begin
                  bin_in    = magnitude;
                  bcd_in    = '0;
                  bitcnt_in = BIT_CNT_WIDTH'(VALUE_WIDTH);
                  phase_in  = PH_DABBLE;
               end
            end
         end
         PH_DABBLE: begin
            bcd_in    = {adj[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
            bin_in    = bin_ff << 1;
            bitcnt_in = bitcnt_ff - BIT_CNT_WIDTH'(1);
            if (bitcnt_ff == BIT_CNT_WIDTH'(1)) begin
               phase_in = PH_EMIT;
            end
         end
         PH_EMIT: begin
            if (!shows || ctl.take) begin
               bcd_in = bcd_ff << 4;
               rem_in = rem_ff - REM_WIDTH'(1);
               if (shows) begin
                  started_in = 1'b1;
               end
               if (rem_ff == REM_WIDTH'(1)) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      bitcnt_ff  <= bitcnt_in;
      rem_ff     <= rem_in;
      started_ff <= started_in;
   end

endmodule

FILE: sim/tb.sv
// self-checking testbench for format_stream_int_to_ascii: format bytes with random
// arguments and idle gaps, every output character checked against a local printf model
// depends on fsia_pkg and format_stream_int_to_ascii
`timescale 1ns / 100ps

module tb;
   import fsia_pkg::*;

   typedef struct {
      logic [CHAR_WIDTH-1:0] fmt;
      logic [ARG_WIDTH-1:0]  arg;
      logic                  sof;
      int                    gap;
      bit                    drain;
   } fmt_item_type;

   typedef struct {
      logic [CHAR_WIDTH-1:0]  chr;
      logic                   is_last;
      logic [COUNT_WIDTH-1:0] count;
   } char_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CHAR_WIDTH-1:0]  req_format_char = '0;
   logic [ARG_WIDTH-1:0]   req_argument = '0;
   logic                   req_start_of_format = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CHAR_WIDTH-1:0]  rsp_out_char;
   logic                   rsp_last_of_run;
   logic [COUNT_WIDTH-1:0] rsp_char_count;

   fmt_item_type    format_q[$];
   char_result_type char_q[$];
   fmt_item_type    cur_item;
   bit              loaded;
   int              gap_left;
   int              items_built;
   int              chars_predicted;
   int              chars_received;
   int              chars_seen;
   int              rsp_hold;
   int              errors;

   // printf model state
   logic                   pct_armed;
   logic [COUNT_WIDTH-1:0] emit_count;

   format_stream_int_to_ascii u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_format_char     (req_format_char),
      .req_argument        (req_argument),
      .req_start_of_format (req_start_of_format),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_char        (rsp_out_char),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_char_count      (rsp_char_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [ARG_WIDTH-1:0] rand_arg();
      logic [ARG_WIDTH-1:0] v;
      v = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 3) == 0) begin
         v = -v;
      end
      return v;
   endfunction

   task automatic add_item(input logic [CHAR_WIDTH-1:0] fmt, input logic [ARG_WIDTH-1:0] arg,
                           input logic sof, input bit drain = 1'b0);
      fmt_item_type it;
      it.fmt   = fmt;
      it.arg   = arg;
      it.sof   = sof;
      it.drain = drain;
      // stretches of back-to-back transfers between idle phases
      it.gap   = ((items_built / 40) % 3 == 1) ? 0 : $urandom_range(0, 19);
      format_q.push_back(it);
      items_built++;
   endtask

   task automatic predict_text(input logic [CHAR_WIDTH-1:0] fmt,
                               input logic [ARG_WIDTH-1:0] arg, input logic sof);
      logic [CHAR_WIDTH-1:0] chars[$];
      logic [CHAR_WIDTH-1:0] digs[$];
      logic [ARG_WIDTH-1:0]  mag;
      logic [ARG_WIDTH-1:0]  base;
      logic [3:0]            dig;
      char_result_type       res;
      bit                    convert;
      convert = 1'b0;
      if (sof) begin
         emit_count = '0;
         pct_armed  = 1'b0;
      end
      if (pct_armed) begin
         pct_armed = 1'b0;
         if (fmt == CHAR_DEC) begin
            convert = 1'b1;
            base    = 10;
            mag     = arg;
            if (arg[ARG_WIDTH-1]) begin
               chars.push_back(CHAR_MINUS);
               mag = -arg;
            end
         end else if (fmt == CHAR_HEX) begin
            convert = 1'b1;
            base    = 16;
            mag     = arg;
         end
      end else if (fmt == CHAR_PERCENT) begin
         pct_armed = 1'b1;
      end else begin
         chars.push_back(fmt);
      end
      if (convert) begin
         do begin
            dig = 4'(mag % base);
            digs.push_front(dig < 4'd10 ? CHAR_ZERO + CHAR_WIDTH'(dig)
                                        : CHAR_LOWER_A + CHAR_WIDTH'(dig - 4'd10));
            mag = mag / base;
         end while (mag != 0);
         chars = {chars, digs};
      end
      foreach (chars[i]) begin
         if (emit_count != COUNT_MAX) begin
            emit_count++;
         end
         res.chr     = chars[i];
         res.is_last = (i == chars.size() - 1);
         res.count   = emit_count;
         char_q.push_back(res);
         chars_predicted++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         loaded = 1'b0;
         pct_armed = 1'b0;
         emit_count = '0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_text(req_format_char, req_argument, req_start_of_format);
            loaded = 1'b0;
         end
         if (!loaded && format_q.size() != 0) begin
            cur_item = format_q.pop_front();
            gap_left = cur_item.gap;
            loaded   = 1'b1;
         end
         if (loaded && gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (loaded && (!cur_item.drain || chars_predicted == chars_received)) begin
            req_valid           <= 1'b1;
            req_format_char     <= cur_item.fmt;
            req_argument        <= cur_item.arg;
            req_start_of_format <= cur_item.sof;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      char_result_type exp_res;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            chars_received <= chars_received + 1;
            chars_seen++;
            if (char_q.size() == 0) begin
               $display("%0t: unexpected character: expected none, actual 0x%02h",
                        $time, rsp_out_char);
               errors++;
            end else begin
               exp_res = char_q.pop_front();
               if (rsp_out_char !== exp_res.chr) begin
                  $display("%0t: out_char: expected 0x%02h, actual 0x%02h",
                           $time, exp_res.chr, rsp_out_char);
                  errors++;
               end
               if (rsp_last_of_run !== exp_res.is_last) begin
                  $display("%0t: last_of_run: expected %0d, actual %0d",
                           $time, exp_res.is_last, rsp_last_of_run);
                  errors++;
               end
               if (rsp_char_count !== exp_res.count) begin
                  $display("%0t: char_count: expected %0d, actual %0d",
                           $time, exp_res.count, rsp_char_count);
                  errors++;
               end
            end
            rsp_hold = ((chars_seen / 50) % 3 == 2) ? 0 : $urandom_range(0, 19);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int kind;
      int n;
      logic sof;
      errors = 0;
      chars_predicted = 0;
      chars_received = 0;
      chars_seen = 0;
      items_built = 0;

      // directed part
      add_item("H", 32'h0, 1'b1);
      add_item(8'h00, 32'hffffffff, 1'b0);
      add_item(8'hff, 32'h0, 1'b0);
      add_item(CHAR_PERCENT, 32'h0, 1'b0);
      add_item(CHAR_DEC, 32'h0, 1'b0);
      add_item(CHAR_PERCENT, 32'h0, 1'b0);
      add_item(CHAR_DEC, 32'h80000000, 1'b0);
      add_item(CHAR_PERCENT, 32'h0, 1'b0);
      add_item(CHAR_DEC, 32'h7fffffff, 1'b0);
      add_item(CHAR_PERCENT, 32'h0, 1'b0);
      add_item(CHAR_DEC, 32'hffffffff, 1'b0);
      add_item(CHAR_PERCENT, 32'h0, 1'b0);
      add_item(CHAR_HEX, 32'h0, 1'b0);
      add_item(CHAR_PERCENT, 32'h0, 1'b0);
      add_item(CHAR_HEX, 32'hffffffff, 1'b0);
      // double percent, then a plain x
      add_item(CHAR_PERCENT, 32'h0, 1'b0);
      add_item(CHAR_PERCENT, 32'h0, 1'b0);
      add_item(CHAR_HEX, 32'h1234abcd, 1'b0);
      // unknown conversion
      add_item(CHAR_PERCENT, 32'h0, 1'b0);
      add_item("s", 32'h55aa55aa, 1'b0);
      // start flag drops a pending percent
      add_item(CHAR_PERCENT, 32'h0, 1'b0);
      add_item(CHAR_DEC, 32'h12345678, 1'b1, 1'b1);
      add_item(CHAR_PERCENT, 32'h0, 1'b0);
      add_item(CHAR_HEX, 32'h80000000, 1'b0);

      // random part
      n = 0;
      while (n < 250) begin
         kind = $urandom_range(0, 9);
         sof  = ($urandom_range(0, 15) == 0);
         case (kind)
            0, 1, 2, 3: begin
               add_item(CHAR_PERCENT, $urandom, sof);
               add_item($urandom_range(0, 1) ? CHAR_DEC : CHAR_HEX, rand_arg(), 1'b0,
                        n == 130);
               n += 2;
            end
            4, 5, 6: begin
               add_item(CHAR_WIDTH'($urandom_range(0, 255)), $urandom, sof);
               n += 1;
            end
            7: begin
               add_item(CHAR_PERCENT, $urandom, sof);
               add_item(CHAR_WIDTH'($urandom_range(0, 255)), rand_arg(),
                        $urandom_range(0, 7) == 0);
               n += 2;
            end
            8: begin
               add_item(CHAR_PERCENT, $urandom, sof);
               add_item(CHAR_PERCENT, $urandom, 1'b0);
               n += 2;
            end
            default: begin
               add_item(CHAR_WIDTH'($urandom_range(32, 126)), $urandom, 1'b1);
               n += 1;
            end
         endcase
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (loaded || format_q.size() != 0 || req_valid || char_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
design/fsia_pkg.sv
design/fsia_digits.sv
design/format_stream_int_to_ascii.sv
sim/tb.sv
